/* rtl/core/pptb_pkg.sv */
// Shared widths, command codes, reset values and unit status type of the packet pacer.
package pptb_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned BatchW = 16;
  localparam int unsigned TickW  = 20;
  localparam int unsigned DataW  = 32;
  localparam int unsigned BurstW = 16;
  localparam int unsigned AdjW   = DataW + 1;
  localparam int unsigned ProdW  = AdjW + BurstW;
  localparam int unsigned NumW   = ProdW + 1;
  localparam int unsigned AddrW  = 3;

  localparam int unsigned MulSteps = BurstW;
  localparam int unsigned DivSteps = DataW;

  localparam logic [CmdW-1:0] CmdRefresh  = 3'd0;
  localparam logic [CmdW-1:0] CmdSchedule = 3'd1;
  localparam logic [CmdW-1:0] CmdSent     = 3'd2;
  localparam logic [CmdW-1:0] CmdLoss     = 3'd3;
  localparam logic [CmdW-1:0] CmdQuery    = 3'd4;
  localparam logic [CmdW-1:0] CmdAppLim   = 3'd5;

  localparam logic RegBatch = 1'b0;
  localparam logic RegTick  = 1'b1;

  localparam logic [BatchW-1:0] ResetBatch = 16'd5;
  localparam logic [TickW-1:0]  ResetTick  = 20'd1000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

/* rtl/core/pptb_cfg.sv */
// APB-style register file: batch limit and timer tick.
module pptb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pptb_pkg::AddrW-1:0]    paddr,
  input  logic [pptb_pkg::DataW-1:0]    pwdata,
  output logic [pptb_pkg::DataW-1:0]    prdata,
  output logic [pptb_pkg::BatchW-1:0]   batch_limit_o,
  output logic [pptb_pkg::TickW-1:0]    timer_tick_o
);
  import pptb_pkg::*;

  logic [BatchW-1:0] batch_q;
  logic [TickW-1:0]  tick_q;
  logic              wr;

  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= ResetBatch;
      tick_q  <= ResetTick;
    end else if (wr) begin
      unique case (paddr[2])
        RegBatch: batch_q <= pwdata[BatchW-1:0];
        RegTick:  tick_q  <= pwdata[TickW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegBatch: prdata = {{(DataW-BatchW){1'b0}}, batch_q};
      RegTick:  prdata = {{(DataW-TickW){1'b0}}, tick_q};
      default:  prdata = '0;
    endcase
  end

  assign batch_limit_o = batch_q;
  assign timer_tick_o  = tick_q;

endmodule

/* rtl/core/pptb_mul.sv */
// Shift-add multiplier: one burst bit per cycle into a narrow accumulator.
module pptb_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pptb_pkg::AdjW-1:0]     a_i,
  input  logic [pptb_pkg::BurstW-1:0]   b_i,
  output pptb_pkg::unit_st_t            st_o,
  output logic [pptb_pkg::ProdW-1:0]    prod_o
);
  import pptb_pkg::*;

  localparam int unsigned CntW = $clog2(MulSteps);

  logic [AdjW-1:0]   hi_q, m_q;
  logic [BurstW-1:0] lo_q;
  logic [AdjW:0]     t;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;

  // add the multiplicand when the low multiplier bit is set, then shift right
  assign t = lo_q[0] ? ({1'b0, hi_q} + {1'b0, m_q}) : {1'b0, hi_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      m_q  <= a_i;
    end else if (busy_q) begin
      hi_q <= t[AdjW:1];
      lo_q <= {t[0], lo_q[BurstW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MulSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign prod_o    = {hi_q, lo_q};

endmodule

/* rtl/core/pptb_div.sv */
// Restoring divider, one quotient bit per cycle; saturates when the quotient needs over 32 bits.
module pptb_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pptb_pkg::NumW-1:0]     num_i,
  input  logic [pptb_pkg::DataW-1:0]    den_i,
  output pptb_pkg::unit_st_t            st_o,
  output logic [pptb_pkg::DataW-1:0]    quot_o
);
  import pptb_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps);
  localparam int unsigned HiW  = NumW - DataW;

  logic [DataW-1:0] rem_q, quo_q, den_q;
  logic [DataW:0]   r2, diff;
  logic             ge, ovf;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  // quotient fits in 32 bits only if the upper dividend part is below the divisor
  assign ovf  = {{(DataW-HiW){1'b0}}, num_i[NumW-1:DataW]} >= den_i;
  assign r2   = {rem_q, quo_q[DataW-1]};
  assign diff = r2 - {1'b0, den_q};
  assign ge   = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= {{(DataW-HiW){1'b0}}, num_i[NumW-1:DataW]};
      quo_q <= ovf ? '1 : num_i[DataW-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DataW-1:0] : r2[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= ~ovf;
        done_q <= ovf;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign quot_o    = quo_q;

endmodule

/* rtl/core/packet_pacer_token_bucket_unit.sv */
// Top level of the token-bucket packet pacer: event decode, pacer state and result register.
//
// One event word in, one result word out. Refresh, schedule, sent, loss,
// app-limited and most batch queries finish in the cycle they are taken;
// the next word follows unless the result register is stalled. A batch
// query that credits the time elapsed since a scheduled write computes
// ceil(adj * burst / interval) with a shift-add multiplier (one burst bit
// at a time) and a restoring divider (one quotient bit at a time, or all at
// once when the quotient saturates); it steps through the multiply, divide
// and finish states, stalling input until its result is loaded. The result
// register lets the next word in on the cycle its word is taken downstream.
module packet_pacer_token_bucket_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pptb_pkg::AddrW-1:0]    paddr,
  input  logic [pptb_pkg::DataW-1:0]    pwdata,
  output logic [pptb_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pptb_pkg::CmdW-1:0]     cmd_i,
  input  logic [pptb_pkg::DataW-1:0]    rtt_us_i,
  input  logic [pptb_pkg::DataW-1:0]    rate_interval_us_i,
  input  logic [pptb_pkg::BurstW-1:0]   rate_burst_i,
  input  logic [pptb_pkg::DataW-1:0]    now_us_i,
  input  logic                          app_limited_flag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pptb_pkg::DataW-1:0]    write_batch_o,
  output logic [pptb_pkg::DataW-1:0]    wait_us_o,
  output logic [pptb_pkg::DataW-1:0]    cached_batch_o
);
  import pptb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b);
    logic [DataW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DataW] ? '1 : s[DataW-1:0];
  endfunction

  logic [BatchW-1:0] batch_limit;
  logic [TickW-1:0]  timer_tick;

  logic [1:0]        state_q, state_d;
  logic [DataW-1:0]  tok_q, tok_d, intv_q, intv_d, cached_q, cached_d, sched_q, sched_d;
  logic [BurstW-1:0] burst_q, burst_d;
  logic              sval_q, sval_d, alim_q, alim_d;

  logic              out_valid_q;
  logic [DataW-1:0]  wb_q, wait_q, cb_q;
  logic [DataW-1:0]  batch, wait_v;
  logic              acc, slow, fin, load, out_free;

  logic [AdjW-1:0]   adj;
  logic [ProdW-1:0]  prod;
  logic [NumW-1:0]   num;
  logic [DataW-1:0]  quot;
  logic              mul_start, div_start;
  unit_st_t          mul_st, div_st;

  pptb_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .batch_limit_o (batch_limit),
    .timer_tick_o  (timer_tick)
  );

  assign pready = 1'b1;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) | (out_valid_q & out_stall_i);
  assign acc        = in_valid_i & ~in_stall_o;
  assign fin        = (state_q == ST_FIN) & out_free;

  assign adj       = {1'b0, now_us_i - sched_q} + {1'b0, intv_q};
  assign mul_start = acc & slow;
  assign div_start = (state_q == ST_MUL) & mul_st.done;
  // interval is nonzero on this path, so interval - 1 cannot wrap
  assign num       = {1'b0, prod} + {{(NumW-DataW){1'b0}}, intv_q - 1'b1};

  pptb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (adj),
    .b_i     (burst_q),
    .st_o    (mul_st),
    .prod_o  (prod)
  );

  pptb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (intv_q),
    .st_o    (div_st),
    .quot_o  (quot)
  );

  always_comb begin
    tok_d    = tok_q;
    intv_d   = intv_q;
    burst_d  = burst_q;
    cached_d = cached_q;
    sched_d  = sched_q;
    sval_d   = sval_q;
    alim_d   = alim_q;
    batch    = '0;
    slow     = 1'b0;
    if (acc) begin
      case (cmd_i)
        CmdRefresh: begin
          if (rtt_us_i < {{(DataW-TickW){1'b0}}, timer_tick}) begin
            intv_d   = '0;
            burst_d  = batch_limit;
            cached_d = {{(DataW-BatchW){1'b0}}, batch_limit};
          end else begin
            intv_d   = rate_interval_us_i;
            burst_d  = rate_burst_i;
            tok_d    = sat_add(tok_q, {{(DataW-BurstW){1'b0}}, rate_burst_i});
            cached_d = {{(DataW-BurstW){1'b0}}, rate_burst_i};
          end
        end
        CmdSchedule: begin
          sched_d = now_us_i;
          sval_d  = 1'b1;
        end
        CmdSent: begin
          if (tok_q != '0) tok_d = tok_q - 1'b1;
        end
        CmdLoss: tok_d = '0;
        CmdQuery: begin
          sval_d = 1'b0;
          if (alim_q) begin
            cached_d = {{(DataW-BatchW){1'b0}}, batch_limit};
            batch    = {{(DataW-BatchW){1'b0}}, batch_limit};
          end else if (intv_q == '0) begin
            batch = {{(DataW-BurstW){1'b0}}, burst_q};
          end else if (!sval_q || sched_q >= now_us_i) begin
            batch = tok_q;
          end else begin
            slow = 1'b1;
          end
        end
        CmdAppLim: alim_d = app_limited_flag_i;
        default: ;
      endcase
    end
    if (fin) begin
      cached_d = quot;
      if (quot > {{(DataW-BurstW){1'b0}}, burst_q}) begin
        tok_d = sat_add(tok_q, quot - {{(DataW-BurstW){1'b0}}, burst_q});
      end
      batch = tok_d;
    end
    wait_v = (alim_d || tok_d != '0) ? '0 : intv_d;
  end

  assign load = (acc & ~slow) | fin;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (mul_start) state_d = ST_MUL;
      ST_MUL:  if (mul_st.done) state_d = ST_DIV;
      ST_DIV:  if (div_st.done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tok_q       <= {{(DataW-BatchW){1'b0}}, ResetBatch};
      intv_q      <= '0;
      burst_q     <= ResetBatch;
      cached_q    <= {{(DataW-BatchW){1'b0}}, ResetBatch};
      sched_q     <= '0;
      sval_q      <= 1'b0;
      alim_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tok_q    <= tok_d;
      intv_q   <= intv_d;
      burst_q  <= burst_d;
      cached_q <= cached_d;
      sched_q  <= sched_d;
      sval_q   <= sval_d;
      alim_q   <= alim_d;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      wb_q   <= batch;
      wait_q <= wait_v;
      cb_q   <= cached_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_batch_o  = wb_q;
  assign wait_us_o      = wait_q;
  assign cached_batch_o = cb_q;

  // no word taken while a long query is in flight
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("word accepted during long query");

  a_mul_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (mul_st.busy || mul_st.done))
    else $error("multiplier idle while sequencer waits on it");

  a_div_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_st.busy || div_st.done))
    else $error("divider idle while sequencer waits on it");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> out_valid_o)
    else $error("long query finished without a result word");

endmodule
